// ===== hdl/slid_pkg.sv =====
// Package for the sorted list: sizes, codes and the item and cell control types.
package slid_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [3:0] position;
      logic [4:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic               ins_en;
      logic               del_en;
      logic signed [31:0] value;
   } cell_ctrl_type;

   typedef struct packed {
      logic lt;
      logic le;
      logic eq;
   } cell_flags_type;

endpackage

// ===== hdl/slid_cell.sv =====
// One cell of the sorted row: holds one entry and shifts with its neighbors.
module slid_cell
   import slid_pkg::*;
(
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic               valid,
   input  logic               left_le,
   input  logic signed [31:0] left_entry,
   input  logic signed [31:0] right_entry,
   output logic signed [31:0] entry,
   output cell_flags_type     flags
);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;

   assign entry    = entry_ff;
   assign flags.lt = valid && (entry_ff < ctrl.value);
   assign flags.le = valid && (entry_ff <= ctrl.value);
   assign flags.eq = valid && (entry_ff == ctrl.value);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en && !flags.le) begin
         entry_in = left_le ? ctrl.value : left_entry;
      end else if (ctrl.del_en && !flags.lt) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/sorted_list_insert_delete_top.sv =====
// Top level of the sorted list: cell row, position encoders, count and result register.
// The list keeps up to CAPACITY signed entries in ascending order in a row of cells.
// Every cell compares its entry with the item's value in the same cycle, and the
// row shifts up on an insert or down on a delete as the item is taken, so one item is
// taken per cycle and its result appears in the output register on the next cycle.
// The rate is limited only by the result register: a new item is taken whenever the
// register is empty or its item is being taken at the same edge.
module sorted_list_insert_delete_top
   import slid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   cell_ctrl_type      ctrl;
   logic signed [31:0] entry      [CAPACITY];
   logic signed [31:0] left_entry [CAPACITY];
   logic signed [31:0] right_entry[CAPACITY];
   cell_flags_type     flags      [CAPACITY];
   logic               valid      [CAPACITY];
   logic               left_le    [CAPACITY];
   logic               left_lt    [CAPACITY];

   logic             req_fire;
   logic             full;
   logic             found;
   logic [IDX_W-1:0] ins_pos;
   logic [IDX_W-1:0] del_pos;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign full      = (count_ff == CAP_CNT);

   assign ctrl.value  = req_data.value;
   assign ctrl.ins_en = req_fire && (req_data.operation == OP_INSERT) && !full;
   assign ctrl.del_en = req_fire && (req_data.operation == OP_DELETE) && found;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign valid[i] = (CNT_W'(i) < count_ff);
      if (i == 0) begin : g_first
         assign left_le[i]    = 1'b1;
         assign left_lt[i]    = 1'b1;
         assign left_entry[i] = req_data.value;
      end else begin : g_inner
         assign left_le[i]    = flags[i-1].le;
         assign left_lt[i]    = flags[i-1].lt;
         assign left_entry[i] = entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry[i] = entry[i];
      end else begin : g_below
         assign right_entry[i] = entry[i+1];
      end

      slid_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .valid       (valid[i]),
         .left_le     (left_le[i]),
         .left_entry  (left_entry[i]),
         .right_entry (right_entry[i]),
         .entry       (entry[i]),
         .flags       (flags[i])
      );
   end

   always_comb begin
      ins_pos = '0;
      del_pos = '0;
      found   = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (left_le[i] && !flags[i].le) begin
            ins_pos = ins_pos | IDX_W'(i);
         end
         if (left_lt[i] && !flags[i].lt) begin
            del_pos = del_pos | IDX_W'(i);
         end
         found = found | flags[i].eq;
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.position = '0;
         if (req_data.operation == OP_INSERT) begin
            if (full) begin
               rsp_data_in.status = ST_FULL;
            end else begin
               rsp_data_in.status   = ST_OK;
               rsp_data_in.position = 4'(ins_pos);
               count_in             = count_ff + 1'b1;
            end
         end else begin
            if (count_ff == '0) begin
               rsp_data_in.status = ST_EMPTY;
            end else if (!found) begin
               rsp_data_in.status = ST_NOTFOUND;
            end else begin
               rsp_data_in.status   = ST_OK;
               rsp_data_in.position = 4'(del_pos);
               count_in             = count_ff - 1'b1;
            end
         end
         rsp_data_in.entry_count = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("count exceeds capacity");

   a_error_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_OK) |-> (rsp_data_ff.position == '0))
      else $error("error result with nonzero position");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.operation == OP_INSERT && !full)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not raise count");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> (count_ff == $past(count_ff)))
      else $error("count changed without an item");
`endif

endmodule

// ===== tb/tb_sorted_list_insert_delete_top.sv =====
// Testbench for the sorted list: directed and random inserts and deletes, checked against typed results or a predictor.
module tb_sorted_list_insert_delete_top;
   import slid_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 850;
   localparam int QUIET_FROM   = 750;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 60;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } list_step_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic signed [31:0] list_vals [CAPACITY];
   int                 list_count = 0;
   rsp_type            list_rsp_q [$];
   list_step_type      directed_rows [$];
   int                 items_sent = 0;
   int                 mismatches = 0;
   bit                 quiet_tail = 1'b0;
   bit                 hold_on = 1'b0;

   sorted_list_insert_delete_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic rsp_type predict_list_op(req_type r);
      rsp_type            res;
      logic signed [31:0] v;
      int                 pos;
      int                 i;
      v = r.value;
      res.status = ST_OK;
      res.position = '0;
      pos = 0;
      if (r.operation == OP_INSERT) begin
         if (list_count >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            while (pos < list_count && !(v < list_vals[pos])) pos++;
            for (i = list_count; i > pos; i--) list_vals[i] = list_vals[i-1];
            list_vals[pos] = v;
            list_count++;
            res.position = 4'(pos);
         end
      end else if (list_count == 0) begin
         res.status = ST_EMPTY;
      end else begin
         while (pos < list_count && list_vals[pos] != v) pos++;
         if (pos >= list_count) begin
            res.status = ST_NOTFOUND;
         end else begin
            for (i = pos; i + 1 < list_count; i++) list_vals[i] = list_vals[i+1];
            list_count--;
            res.position = 4'(pos);
         end
      end
      res.entry_count = 5'(list_count);
      return res;
   endfunction

   function automatic logic signed [31:0] pick_value(bit from_list);
      int sel;
      sel = $urandom_range(0, 99);
      if (from_list && list_count > 0)
         return list_vals[$urandom_range(0, list_count - 1)];
      if (sel < 45)
         return $signed(32'($urandom_range(0, 16))) - 32'sd8;
      if (sel < 70) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $signed($urandom());
   endfunction

   task automatic add_row(op_type op, logic signed [31:0] v, bit typed,
                          status_type st, int pos, int cnt);
      list_step_type row;
      row.req.operation = op;
      row.req.value = v;
      row.typed = typed;
      row.rsp.status = st;
      row.rsp.position = 4'(pos);
      row.rsp.entry_count = 5'(cnt);
      directed_rows.push_back(row);
   endtask

   task automatic send_request(req_type r, bit typed, rsp_type typed_rsp);
      rsp_type predicted;
      int      gap;
      if (!quiet_tail && !hold_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_list_op(r);
      list_rsp_q.push_back(typed ? typed_rsp : predicted);
      items_sent++;
   endtask

   task automatic note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (list_rsp_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result %p", rsp_data));
         end else begin
            exp_rsp = list_rsp_q.pop_front();
            if (rsp_data.status !== exp_rsp.status ||
                rsp_data.position !== exp_rsp.position ||
                rsp_data.entry_count !== exp_rsp.entry_count)
               note_mismatch($sformatf(
                  "expected status %0d position %0d count %0d, got %0d %0d %0d",
                  exp_rsp.status, exp_rsp.position, exp_rsp.entry_count,
                  rsp_data.status, rsp_data.position, rsp_data.entry_count));
         end
      end
   end

   initial begin
      bit hold_done;
      hold_done = 1'b0;
      wait (!reset);
      forever begin
         if (!quiet_tail && !hold_done && items_sent >= HOLD_AT) begin
            hold_on = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_on = 1'b0;
            hold_done = 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin
      req_type r;
      rsp_type none;
      int      ins_pct;
      bit      is_insert;
      none = '0;
      ins_pct = 50;

      add_row(OP_DELETE, 32'sd0, 1, ST_EMPTY, 0, 0);
      add_row(OP_INSERT, 32'sh7FFF_FFFF, 1, ST_OK, 0, 1);
      add_row(OP_INSERT, 32'sh8000_0000, 1, ST_OK, 0, 2);
      add_row(OP_DELETE, 32'sd5, 1, ST_NOTFOUND, 0, 2);
      add_row(OP_INSERT, 32'sd0, 1, ST_OK, 1, 3);
      add_row(OP_INSERT, 32'sd0, 1, ST_OK, 2, 4);
      add_row(OP_INSERT, -32'sd1, 0, ST_OK, 0, 0);
      add_row(OP_DELETE, 32'sd0, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 32'sd100, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, -32'sd100, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 32'sd7, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 32'sd7, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 32'sh4000_0000, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 32'shC000_0000, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 32'sd3, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 32'sd2, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 32'sd1, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, -32'sd2, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, -32'sd3, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 32'sd8, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 32'sd9, 1, ST_FULL, 0, 16);
      add_row(OP_DELETE, 32'sh7FFF_FFFF, 1, ST_OK, 15, 15);
      add_row(OP_DELETE, 32'sh8000_0000, 1, ST_OK, 0, 14);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k])
         send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].rsp);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: ins_pct = 15;
               1: ins_pct = 50;
               default: ins_pct = 85;
            endcase
         end
         if (n >= QUIET_FROM) quiet_tail = 1'b1;
         is_insert = ($urandom_range(0, 99) < ins_pct);
         r.operation = is_insert ? OP_INSERT : OP_DELETE;
         r.value = pick_value(is_insert ? ($urandom_range(0, 99) < 30)
                                        : ($urandom_range(0, 99) < 75));
         send_request(r, 1'b0, none);
      end
      req_valid <= 1'b0;

      while (list_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("sorted_list_insert_delete_top test passed");
      end else begin
         $display("sorted_list_insert_delete_top test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("sorted_list_insert_delete_top test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/slid_pkg.sv
hdl/slid_cell.sv
hdl/sorted_list_insert_delete_top.sv
tb/tb_sorted_list_insert_delete_top.sv
